// ----- rtl/deq_pkg.sv -----
// Shared types and constants of the double-ended queue.
`timescale 1ns / 1ps
package deq_pkg;

	localparam int unsigned WordWidth   = 32;
	localparam int unsigned OpWidth     = 2;
	localparam int unsigned StatusWidth = 2;
	localparam int unsigned CountWidth  = 5;

	typedef enum logic [OpWidth-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} opcode_t;

	typedef enum logic [StatusWidth-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture the accepted item
		logic exec;   // apply the captured operation
	} dp_cmd_t;

endpackage

// ----- rtl/deq_if.sv -----
// Handshake channels of the double-ended queue: request and response.
`timescale 1ns / 1ps
interface deq_req_if;
	logic                                valid;
	logic                                ready;
	logic [deq_pkg::OpWidth-1:0]         opcode;
	logic signed [deq_pkg::WordWidth-1:0] push_value;

	modport source (output valid, output opcode, output push_value, input ready);
	modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface deq_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [deq_pkg::WordWidth-1:0] removed_value;
	logic [deq_pkg::StatusWidth-1:0]      status;
	logic                                 is_empty;
	logic [deq_pkg::CountWidth-1:0]       entry_count;

	modport source (output valid, output removed_value, output status,
		output is_empty, output entry_count, input ready);
	modport sink   (input valid, input removed_value, input status,
		input is_empty, input entry_count, output ready);
endinterface

// ----- rtl/deq_ctrl.sv -----
// Sequencing state machine of the double-ended queue.
`timescale 1ns / 1ps
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output deq_pkg::dp_cmd_t  cmd
);

	deq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			deq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = deq_pkg::S_EXEC;
				end
			end
			deq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = deq_pkg::S_DONE;
			end
			deq_pkg::S_DONE: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					state_d = deq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = deq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/deq_dp.sv -----
// Ring store, front pointer and count of the double-ended queue.
`timescale 1ns / 1ps
module deq_dp #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  deq_pkg::dp_cmd_t                      cmd,
	input  logic [deq_pkg::OpWidth-1:0]           opcode,
	input  logic signed [deq_pkg::WordWidth-1:0]  push_value,
	output logic signed [deq_pkg::WordWidth-1:0]  removed_value,
	output logic [deq_pkg::StatusWidth-1:0]       status,
	output logic                                  is_empty,
	output logic [deq_pkg::CountWidth-1:0]        entry_count
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LastSlot = PW'(DEPTH - 1);
	localparam logic [PW:0]   DepthW   = (PW + 1)'(DEPTH);
	localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);

	logic [deq_pkg::WordWidth-1:0] mem [DEPTH];

	logic [PW-1:0]                 front_q;
	logic [CW-1:0]                 cnt_q;
	deq_pkg::opcode_t              op_q;
	logic [deq_pkg::WordWidth-1:0] val_q;
	logic [deq_pkg::WordWidth-1:0] rd_q;
	deq_pkg::status_t              status_q;
	logic                          pop_ok_q;

	logic          is_push, is_full, is_none;
	logic [CW-1:0] back_off;
	logic [PW:0]   back_sum;
	logic [PW-1:0] back_slot, prev_slot, next_slot, slot;

	assign is_push = (op_q == deq_pkg::OP_PUSH_FRONT) || (op_q == deq_pkg::OP_PUSH_BACK);
	assign is_full = (cnt_q == FullCnt);
	assign is_none = (cnt_q == '0);

	// offset of the back slot: count for a push, count-1 for a pop
	assign back_off  = is_push ? cnt_q : cnt_q - CW'(1);
	assign back_sum  = (PW + 1)'(front_q) + (PW + 1)'(back_off);
	assign back_slot = (back_sum >= DepthW) ? PW'(back_sum - DepthW) : PW'(back_sum);
	assign prev_slot = (front_q == '0) ? LastSlot : front_q - PW'(1);
	assign next_slot = (front_q == LastSlot) ? '0 : front_q + PW'(1);

	always_comb begin
		case (op_q)
			deq_pkg::OP_PUSH_FRONT: slot = prev_slot;
			deq_pkg::OP_POP_FRONT:  slot = front_q;
			default:                slot = back_slot;
		endcase
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= deq_pkg::opcode_t'(opcode);
			val_q <= push_value;
		end
	end

	// store access: a write on a push that fits, and a registered read on every execute
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (is_push && !is_full) begin
				mem[slot] <= val_q;
			end
			rd_q <= mem[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			cnt_q    <= '0;
			status_q <= deq_pkg::ST_OK;
			pop_ok_q <= 1'b0;
		end else if (cmd.exec) begin
			pop_ok_q <= 1'b0;
			if (is_push) begin
				if (is_full) begin
					status_q <= deq_pkg::ST_FULL;
				end else begin
					status_q <= deq_pkg::ST_OK;
					cnt_q    <= cnt_q + CW'(1);
					if (op_q == deq_pkg::OP_PUSH_FRONT) begin
						front_q <= prev_slot;
					end
				end
			end else begin
				if (is_none) begin
					status_q <= deq_pkg::ST_EMPTY;
				end else begin
					status_q <= deq_pkg::ST_OK;
					pop_ok_q <= 1'b1;
					cnt_q    <= cnt_q - CW'(1);
					if (op_q == deq_pkg::OP_POP_FRONT) begin
						front_q <= next_slot;
					end
				end
			end
		end
	end

	assign removed_value = pop_ok_q ? rd_q : '0;
	assign status        = status_q;
	assign is_empty      = is_none;
	assign entry_count   = deq_pkg::CountWidth'(cnt_q);

endmodule

// ----- rtl/double_ended_queue.sv -----
// Top level of the bounded double-ended queue of signed words.
//
//  channel  role   fields
//  -------  -----  -----------------------------------------------
//  req      sink   opcode, push_value
//  rsp      source removed_value, status, is_empty, entry_count
//
//  Each item passes through three steps plus the wait on rsp: accept, execute
//  (one access of the ring store port), response. The store read is
//  registered, which sets the execute step apart from the response.
//  req.ready is high only while no item is in flight; one result per item.
//  Reset clears the front pointer and count; the ring store is not
//  cleared, since only pushed entries are ever returned in removed_value.
`timescale 1ns / 1ps
module double_ended_queue #(
	parameter int unsigned DEPTH = 16
) (
	input logic     clk,
	input logic     arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);

	deq_pkg::dp_cmd_t cmd;

	// handshake sequencing
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// ring store with front pointer and count
	deq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (req.opcode),
		.push_value    (req.push_value),
		.removed_value (rsp.removed_value),
		.status        (rsp.status),
		.is_empty      (rsp.is_empty),
		.entry_count   (rsp.entry_count)
	);

endmodule

// ----- bench/double_ended_queue_tb.sv -----
// Self-checking testbench for the bounded double-ended queue.
`timescale 1ns / 1ps
module double_ended_queue_tb;

	localparam int unsigned DEPTH       = 16;
	localparam int unsigned RANDOM_OPS  = 500;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned MAX_GAP     = 16;
	localparam int unsigned DRAIN_WAIT  = 10;

	// one expected response item
	typedef struct packed {
		logic signed [deq_pkg::WordWidth-1:0] removed_value;
		deq_pkg::status_t                     status;
		logic                                 is_empty;
		logic [deq_pkg::CountWidth-1:0]       entry_count;
	} deq_result_t;

	logic clk;
	logic arst_n;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of the ring: words, slot of the front entry, and occupancy.
	logic [deq_pkg::WordWidth-1:0] shadow_words [DEPTH];
	int unsigned                   shadow_front;
	int unsigned                   shadow_count;

	deq_result_t pending_results[$];  // responses owed by the block, oldest first
	int unsigned error_count;
	int unsigned cycle_count;

	bit          quiet;          // when set neither side inserts random idle cycles
	int unsigned rsp_hold_off;   // one-shot long stall of the response side

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Applies one operation to the shadow ring and returns the response it owes.
	// Full pushes and empty pops leave the ring untouched.
	function automatic deq_result_t apply_deque_op(deq_pkg::opcode_t op,
		logic [deq_pkg::WordWidth-1:0] word);
		deq_result_t res;
		int unsigned slot;
		res.removed_value = '0;
		res.status        = deq_pkg::ST_OK;
		case (op)
			deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
				if (shadow_count >= DEPTH) begin
					res.status = deq_pkg::ST_FULL;
				end else if (op == deq_pkg::OP_PUSH_FRONT) begin
					// front moves back one slot, wrapping below zero
					shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
					shadow_words[shadow_front] = word;
					shadow_count++;
				end else begin
					slot = (shadow_front + shadow_count) % DEPTH;
					shadow_words[slot] = word;
					shadow_count++;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					res.status = deq_pkg::ST_EMPTY;
				end else if (op == deq_pkg::OP_POP_FRONT) begin
					res.removed_value = shadow_words[shadow_front];
					shadow_front = (shadow_front + 1) % DEPTH;
					shadow_count--;
				end else begin
					slot = (shadow_front + shadow_count - 1) % DEPTH;
					res.removed_value = shadow_words[slot];
					shadow_count--;
				end
			end
		endcase
		res.is_empty    = (shadow_count == 0);
		res.entry_count = shadow_count[deq_pkg::CountWidth-1:0];
		return res;
	endfunction

	// Offers one item on req after a random gap and waits for it to be taken.
	// valid stays high afterwards so back-to-back items see no bubble.
	task automatic send_op(deq_pkg::opcode_t op, logic [deq_pkg::WordWidth-1:0] word);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= op;
		req_ch.push_value <= word;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		pending_results.insert(pending_results.size(), apply_deque_op(op, word));
	endtask

	// Mostly random words, with the sign-boundary and all-ones/all-zeros patterns mixed in.
	function automatic logic [deq_pkg::WordWidth-1:0] pick_word();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	// Response side: draws a stall per item, then checks each accepted item
	// against the oldest prediction.
	initial begin
		deq_result_t want;
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = (quiet ? 0 : $urandom_range(0, MAX_GAP)) + rsp_hold_off;
			rsp_hold_off = 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
			if (pending_results.size() == 0) begin
				$error("response with no request outstanding: removed_value %0d",
					rsp_ch.removed_value);
				error_count++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (rsp_ch.removed_value !== want.removed_value) begin
					$error("removed_value: expected %0d, actual %0d",
						want.removed_value, rsp_ch.removed_value);
					error_count++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, actual %0d",
						want.is_empty, rsp_ch.is_empty);
					error_count++;
				end
				if (rsp_ch.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
						want.entry_count, rsp_ch.entry_count);
					error_count++;
				end
			end
		end
	end

	// Both pops on the freshly reset queue must report empty.
	task automatic test_empty_pops();
		send_op(deq_pkg::OP_POP_FRONT, 32'h1234_5678);
		send_op(deq_pkg::OP_POP_BACK, 32'hDEAD_BEEF);
	endtask

	// Fill from both ends; the first front push wraps the pointer below slot 0.
	// Sign extremes land at both ends. Then both pushes on a full queue are refused.
	task automatic test_fill_and_full();
		logic [deq_pkg::WordWidth-1:0] words [DEPTH];
		words[0] = 32'h8000_0000;
		words[1] = 32'h7FFF_FFFF;
		words[2] = 32'hFFFF_FFFF;
		words[3] = 32'h0000_0000;
		words[4] = 32'h5555_5555;
		words[5] = 32'hAAAA_AAAA;
		for (int i = 6; i < DEPTH; i++) words[i] = $urandom();
		for (int i = 0; i < DEPTH; i++)
			send_op((i % 2 == 0) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
				words[i]);
		send_op(deq_pkg::OP_PUSH_FRONT, 32'h0BAD_0BAD);
		send_op(deq_pkg::OP_PUSH_BACK, 32'h0BAD_F00D);
	endtask

	// Take one word off each end of the full queue.
	task automatic test_pop_both_ends();
		send_op(deq_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
		send_op(deq_pkg::OP_POP_BACK, 32'h0000_0000);
	endtask

	// Response side stalls for a long stretch while the sender keeps offering
	// back-to-back items, so the block holds an item and drops req.ready.
	task automatic test_backpressure();
		bit prev_quiet;
		prev_quiet   = quiet;
		quiet        = 1'b1;
		rsp_hold_off = 300;
		for (int i = 0; i < 30; i++)
			send_op(deq_pkg::opcode_t'($urandom_range(0, 3)), pick_word());
		quiet = prev_quiet;
	endtask

	// Bursts with a push-heavy, pop-heavy or even mix so occupancy swings
	// between empty and full; some bursts run with no idle cycles.
	task automatic test_random_mix();
		int unsigned      done;
		int unsigned      burst;
		int unsigned      mode;
		int unsigned      push_pct;
		bit               is_push;
		deq_pkg::opcode_t op;
		done = 0;
		while (done < RANDOM_OPS) begin
			burst = $urandom_range(20, 60);
			mode  = $urandom_range(0, 2);
			quiet = ($urandom_range(0, 3) == 0);
			push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
			for (int i = 0; i < burst && done < RANDOM_OPS; i++) begin
				is_push = ($urandom_range(0, 99) < push_pct);
				if (is_push)
					op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK
						: deq_pkg::OP_PUSH_FRONT;
				else
					op = $urandom_range(0, 1) ? deq_pkg::OP_POP_BACK
						: deq_pkg::OP_POP_FRONT;
				send_op(op, pick_word());
				done++;
			end
		end
		quiet = 1'b0;
	endtask

	// Main sequence: reset once, run the tests, drain and report.
	initial begin
		error_count  = 0;
		quiet        = 1'b0;
		rsp_hold_off = 0;
		shadow_front = 0;
		shadow_count = 0;
		for (int i = 0; i < DEPTH; i++) shadow_words[i] = '0;

		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.opcode     <= deq_pkg::OP_PUSH_FRONT;
		req_ch.push_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pops();
		test_fill_and_full();
		test_pop_both_ends();
		test_backpressure();
		test_random_mix();

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// let any stray extra response surface before judging
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/double_ended_queue.sv
bench/double_ended_queue_tb.sv
